/* hdl/ffba_pkg.sv */
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 8;
  localparam int LEN_W        = 17;
  localparam int NEED_W       = LEN_W + 1;
  localparam int REQ_W        = 17;
  localparam int ADDR_W       = 32;
  localparam int STATUS_W     = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic claim;
    logic release_blk;
    logic append;
    logic fail_space;
    logic fail_addr;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic at_end;
    logic hit;
    logic fits;
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/ffba_ctrl.sv */
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.at_end || stat_i.hit) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.start = req_valid_i;
      end
      S_WALK: begin
        if (stat_i.at_end) begin
          if (stat_i.is_free_op) begin
            cmd_o.fail_addr = 1'b1;
          end else if (stat_i.fits) begin
            cmd_o.append = 1'b1;
          end else begin
            cmd_o.fail_space = 1'b1;
          end
        end else if (stat_i.hit) begin
          if (stat_i.is_free_op) begin
            cmd_o.release_blk = 1'b1;
          end else begin
            cmd_o.claim = 1'b1;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_RESP: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* hdl/ffba_datapath.sv */
module ffba_datapath
  import ffba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [ADDR_W-1:0]   cfg_data_i,
  input  opcode_e             opcode_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [ADDR_W-1:0]   free_address_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ADDR_W-1:0]   result_address_o,
  output status_e             status_o
);

  logic [LEN_W-1:0]      len_mem [MAX_BLOCKS];
  logic [LEN_W-1:0]      rd_len_q;
  logic [ADDR_W-1:0]     heap_base_q;
  logic [CNT_W-1:0]      count_q;
  logic [LEN_W-1:0]      used_q;
  logic [MAX_BLOCKS-1:0] avail_q;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  out_valid_q;

  opcode_e               op_q;
  logic [NEED_W-1:0]     need_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [LEN_W-1:0]      offset_q;
  logic [ADDR_W-1:0]     res_addr_q;
  status_e               res_status_q;
  logic [ADDR_W-1:0]     out_addr_q;
  status_e               out_status_q;

  logic [ADDR_W-1:0]     slot_addr;
  logic [ADDR_W-1:0]     top_addr;
  logic [NEED_W-1:0]     grown;

  assign slot_addr = heap_base_q + ADDR_W'(offset_q) + ADDR_W'(HEADER_BYTES);
  assign top_addr  = heap_base_q + ADDR_W'(used_q) + ADDR_W'(HEADER_BYTES);
  assign grown     = {1'b0, used_q} + need_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      len_mem[count_q[IDX_W-1:0]] <= need_q[LEN_W-1:0];
    end
    rd_len_q <= len_mem[idx_d[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      count_q     <= '0;
      used_q      <= '0;
      avail_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cfg_valid_i) begin
        heap_base_q <= cfg_data_i;
      end
      if (cmd_i.claim) begin
        avail_q[idx_q[IDX_W-1:0]] <= 1'b0;
      end
      if (cmd_i.release_blk) begin
        avail_q[idx_q[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd_i.append) begin
        avail_q[count_q[IDX_W-1:0]] <= 1'b0;
        count_q <= count_q + CNT_W'(1);
        used_q  <= used_q + need_q[LEN_W-1:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q     <= opcode_i;
      need_q   <= {1'b0, request_bytes_i} + NEED_W'(HEADER_BYTES);
      addr_q   <= free_address_i;
      offset_q <= '0;
    end else if (cmd_i.step) begin
      offset_q <= offset_q + rd_len_q;
    end
    if (cmd_i.claim) begin
      res_addr_q   <= slot_addr;
      res_status_q <= ST_OK;
    end else if (cmd_i.release_blk) begin
      res_addr_q   <= '0;
      res_status_q <= ST_OK;
    end else if (cmd_i.append) begin
      res_addr_q   <= top_addr;
      res_status_q <= ST_OK;
    end else if (cmd_i.fail_space) begin
      res_addr_q   <= '0;
      res_status_q <= ST_NO_SPACE;
    end else if (cmd_i.fail_addr) begin
      res_addr_q   <= '0;
      res_status_q <= ST_NOT_FOUND;
    end
    if (cmd_i.emit) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  always_comb begin
    stat_o.is_free_op = (op_q == OP_FREE);
    stat_o.at_end     = (idx_q == count_q);
    if (op_q == OP_FREE) begin
      stat_o.hit = (slot_addr == addr_q);
    end else begin
      stat_o.hit = avail_q[idx_q[IDX_W-1:0]] && ({1'b0, rd_len_q} >= need_q);
    end
    stat_o.fits     = (count_q < CNT_W'(MAX_BLOCKS)) && (grown <= NEED_W'(HEAP_BYTES));
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_status_q;

endmodule

/* hdl/first_fit_block_allocator_core.sv */
// An accepted request walks k blocks (k = 0..64) in S_WALK, then S_RESP registers the result.
// A new request is taken only in S_IDLE, once the last one has left S_RESP; the walk reads one
// block-length entry per cycle from the table memory.
// A result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous) empties the heap and clears heap_base.
module first_fit_block_allocator_core
  import ffba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,      // heap_base
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // request_bytes[16:0], free_address[48:17], zero pad
  input  logic [0:0]  s_axis_tuser_i,  // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // result_address
  output logic [1:0]  m_axis_tuser_o   // status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_e  status;

  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffba_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_e'(s_axis_tuser_i[0])),
    .request_bytes_i  (s_axis_tdata_i[REQ_W-1:0]),
    .free_address_i   (s_axis_tdata_i[REQ_W+ADDR_W-1:REQ_W]),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .result_address_o (m_axis_tdata_o),
    .status_o         (status)
  );

  assign m_axis_tuser_o = status;

endmodule

/* hdl/ffba_checker.sv */
module ffba_checker
  import ffba_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("illegal status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_NO_SPACE || m_axis_tuser_o == ST_NOT_FOUND)
      |-> m_axis_tdata_o == '0)
    else $error("failed request returned an address");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while previous one still walking");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
